/* sv/ccc_pkg.sv */
// shared types, constants and the cell position map of the coincidence cone block
package ccc_pkg;

	localparam int unsigned TDATA_IN_W  = 128;
	localparam int unsigned TDATA_OUT_W = 184;

	localparam int unsigned Q_W   = 25;   // 511 * energy
	localparam int unsigned D_W   = 33;   // e1 * (e1 + e0)
	localparam int unsigned DEN_W = 34;   // divisor 2 * d
	localparam int unsigned HI_W  = 25;   // numerator bits above the quotient bits

	localparam logic [9:0] REST_MASS_KEV = 10'd511;
	localparam logic [31:0] WINDOW_RESET = 32'd50000;

	localparam logic [9:0] CELL_MAP [0:24] = '{
		10'd13,  10'd15,  10'd17,  10'd19,  10'd21,
		10'd53,  10'd55,  10'd57,  10'd59,  10'd61,
		10'd93,  10'd95,  10'd97,  10'd99,  10'd101,
		10'd303, 10'd305, 10'd307, 10'd309, 10'd311,
		10'd503, 10'd505, 10'd507, 10'd509, 10'd511
	};
	localparam logic signed [15:0] ROW_X [0:4] = '{
		16'sd80, 16'sd400, 16'sd720, 16'sd1040, 16'sd1360
	};
	localparam logic signed [15:0] COL_Y [0:4] = '{
		16'sd301, 16'sd473, 16'sd645, 16'sd817, 16'sd989
	};

	typedef struct packed {
		logic              hit;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} ccc_pos_t;

	// operands of a closed two-pulse group
	typedef struct packed {
		logic              valid;
		logic [15:0]        e0;
		logic [15:0]        e1;
		logic signed [15:0] x0;
		logic signed [15:0] y0;
		logic signed [15:0] z0;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] z1;
		logic [31:0]        hist;
	} ccc_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} ccc_state_t;

	function automatic ccc_pos_t ccc_map_cell(input logic [9:0] cell_no);
		ccc_pos_t p;
		p.hit = 1'b0;
		p.x   = '0;
		p.y   = '0;
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				if (CELL_MAP[r * 5 + c] == cell_no) begin
					p.hit = 1'b1;
					p.x   = ROW_X[r];
					p.y   = COL_Y[c];
				end
			end
		end
		return p;
	endfunction

endpackage

/* sv/ccc_group.sv */
// pulse grouping: cell lookup, time gap test and the open group registers
module ccc_group (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [47:0]        time_ps,
	input  logic [15:0]        energy_kev,
	input  logic [9:0]         cell_id,
	input  logic signed [15:0] depth_z,
	input  logic [31:0]        history_id,
	input  logic [31:0]        window_ps,
	output ccc_pkg::ccc_req_t  req
);
	import ccc_pkg::*;

	logic [1:0]         count_q;
	logic [47:0]        last_time_q;
	logic [15:0]        first_energy_q, second_energy_q;
	logic signed [15:0] first_x_q, first_y_q, first_z_q;
	logic signed [15:0] second_x_q, second_y_q, second_z_q;
	logic [31:0]        first_history_q;

	ccc_pos_t    pos;
	logic [48:0] diff_fwd;
	logic [48:0] diff_rev;
	logic [47:0] gap;
	logic        closing;
	logic [1:0]  count_eff;
	logic        take;

	assign pos      = ccc_map_cell(cell_id);
	assign diff_fwd = {1'b0, time_ps} - {1'b0, last_time_q};
	assign diff_rev = {1'b0, last_time_q} - {1'b0, time_ps};
	assign gap      = diff_fwd[48] ? diff_rev[47:0] : diff_fwd[47:0];
	assign closing  = (count_q != 2'd0) && (gap >= {16'd0, window_ps});
	assign count_eff = closing ? 2'd0 : count_q;
	assign take     = accept && pos.hit;

	// old register contents go out as the cone operands
	always_comb begin
		req.valid = take && closing && (count_q == 2'd2);
		req.e0    = first_energy_q;
		req.e1    = second_energy_q;
		req.x0    = first_x_q;
		req.y0    = first_y_q;
		req.z0    = first_z_q;
		req.x1    = second_x_q;
		req.y1    = second_y_q;
		req.z1    = second_z_q;
		req.hist  = first_history_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 2'd0;
			last_time_q <= '0;
		end else if (take) begin
			last_time_q <= time_ps;
			case (count_eff)
				2'd0: count_q <= 2'd1;
				2'd1: count_q <= 2'd2;
				default: count_q <= 2'd3;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && count_eff == 2'd0) begin
			first_energy_q  <= energy_kev;
			first_x_q       <= pos.x;
			first_y_q       <= pos.y;
			first_z_q       <= depth_z;
			first_history_q <= history_id;
		end
		if (take && count_eff == 2'd1) begin
			second_energy_q <= energy_kev;
			second_x_q      <= pos.x;
			second_y_q      <= pos.y;
			second_z_q      <= depth_z;
		end
	end

endmodule

/* sv/ccc_div.sv */
// restoring divider, one quotient bit per cycle
module ccc_div #(
	parameter int DEN_W = 34,
	parameter int QUO_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] num_hi,
	input  logic [QUO_W-1:0] num_lo,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// low numerator bits shift out of the top while quotient bits enter below
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			quo_q <= num_lo;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* sv/ccc_seq.sv */
// cone sequencer: products, rejection tests, divider control, cosine and output register
module ccc_seq #(
	parameter int COS_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ccc_pkg::ccc_req_t                  req,
	output logic                               busy,
	output logic                               div_start,
	output logic [ccc_pkg::DEN_W-1:0]          div_num_hi,
	output logic [COS_FRAC_BITS+1:0]           div_num_lo,
	output logic [ccc_pkg::DEN_W-1:0]          div_den,
	input  logic                               div_done,
	input  logic [COS_FRAC_BITS+1:0]           div_quo,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ccc_pkg::TDATA_OUT_W-1:0]    m_tdata
);
	import ccc_pkg::*;

	localparam int K     = COS_FRAC_BITS + 2;
	localparam int NUM_W = COS_FRAC_BITS + 27;
	localparam int CW    = COS_FRAC_BITS + 3;
	localparam logic signed [CW-1:0] COS_ONE = CW'(1 << COS_FRAC_BITS);
	localparam logic signed [CW-1:0] COS_MAX = CW'((1 << COS_FRAC_BITS) - 1);
	localparam logic signed [CW-1:0] COS_MIN = -COS_MAX;

	ccc_state_t state_q, state_d;

	logic [15:0]        e0_q, e1_q;
	logic signed [15:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
	logic [31:0]        hist_q;
	logic [Q_W-1:0]     q_q;
	logic [D_W-1:0]     d_q;
	logic signed [16:0] axis_x_q, axis_y_q, axis_z_q;
	logic [16:0]        total_q;

	logic               m_tvalid_q;
	logic signed [15:0] o_apex_x_q, o_apex_y_q, o_apex_z_q;
	logic signed [16:0] o_axis_x_q, o_axis_y_q, o_axis_z_q;
	logic [16:0]        o_cos_q;
	logic [16:0]        o_total_q;
	logic [15:0]        o_first_e_q;
	logic [31:0]        o_hist_q;

	logic               reject;
	logic               out_load;
	logic [NUM_W-1:0]   num;
	logic signed [CW-1:0]    cos_raw;
	logic signed [CW-1:0]    cos_sat;
	logic signed [CW+16:0]   cos_wide;

	assign reject = (e0_q == 16'd0) || (e1_q == 16'd0)
		|| ({{(DEN_W-Q_W){1'b0}}, q_q} >= {d_q, 1'b0})
		|| ((axis_x_q == 17'sd0) && (axis_y_q == 17'sd0) && (axis_z_q == 17'sd0));

	// rounded quotient: (q * 2^(F+1) + d) / (2 * d)
	assign num        = (NUM_W'(q_q) << (COS_FRAC_BITS + 1)) + NUM_W'(d_q);
	assign div_num_hi = DEN_W'(num[NUM_W-1:K]);
	assign div_num_lo = num[K-1:0];
	assign div_den    = {d_q, 1'b0};

	assign cos_raw = COS_ONE - $signed({1'b0, div_quo});
	always_comb begin
		if (cos_raw > COS_MAX)
			cos_sat = COS_MAX;
		else if (cos_raw < COS_MIN)
			cos_sat = COS_MIN;
		else
			cos_sat = cos_raw;
	end
	assign cos_wide = (CW+17)'(cos_sat);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req.valid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_CHECK;
			ST_CHECK: state_d = reject ? ST_IDLE : ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_CHECK: div_start = !reject;
			ST_OUT:   out_load = !m_tvalid_q || m_tready;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			e0_q   <= req.e0;
			e1_q   <= req.e1;
			x0_q   <= req.x0;
			y0_q   <= req.y0;
			z0_q   <= req.z0;
			x1_q   <= req.x1;
			y1_q   <= req.y1;
			z1_q   <= req.z1;
			hist_q <= req.hist;
		end
		if (state_q == ST_MUL) begin
			q_q      <= {15'd0, REST_MASS_KEV} * {9'd0, e0_q};
			d_q      <= D_W'(e1_q * ({1'b0, e1_q} + {1'b0, e0_q}));
			axis_x_q <= {x1_q[15], x1_q} - {x0_q[15], x0_q};
			axis_y_q <= {y1_q[15], y1_q} - {y0_q[15], y0_q};
			axis_z_q <= {z1_q[15], z1_q} - {z0_q[15], z0_q};
			total_q  <= {1'b0, e0_q} + {1'b0, e1_q};
		end
		if (out_load) begin
			o_apex_x_q  <= x0_q;
			o_apex_y_q  <= y0_q;
			o_apex_z_q  <= z0_q;
			o_axis_x_q  <= axis_x_q;
			o_axis_y_q  <= axis_y_q;
			o_axis_z_q  <= axis_z_q;
			o_cos_q     <= cos_wide[16:0];
			o_total_q   <= total_q;
			o_first_e_q <= e0_q;
			o_hist_q    <= hist_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, o_hist_q, o_first_e_q, o_total_q, o_cos_q,
		o_axis_z_q, o_axis_y_q, o_axis_x_q, o_apex_z_q, o_apex_y_q, o_apex_x_q};

endmodule

/* sv/compton_coincidence_cone_top.sv */
// top level of the compton coincidence cone builder
//
// Pulses in time order come in on the s_ stream; cells outside the 25-cell map are dropped, the
// rest are grouped by a time gap below window_ps to the last taken pulse. A pulse is taken
// without a stall unless it closes a group of exactly two pulses; then the input stalls while
// the cone tests run and, when the cone passes them, while a restoring divider retires one bit
// of the rounded cosine quotient per cycle and while the m_ side holds the previous cone. Cones
// with a zero energy, a zero axis or a cosine at or beyond -1 are dropped. The last open group
// is held until a later pulse closes it. window_ps resets to 50000; the user is to write it
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
module compton_coincidence_cone_top #(
	parameter int COS_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// time_ps, energy_kev, cell_id, depth_z, history_id, zero pad
	input  logic [127:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// apex_x, apex_y, apex_z, axis_x, axis_y, axis_z, cos_half_angle,
	// total_energy, first_energy_out, cone_history, zero pad
	output logic [183:0] m_tdata,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import ccc_pkg::*;

	localparam int K = COS_FRAC_BITS + 2;

	logic [31:0]        window_q;
	ccc_req_t           req;
	logic               busy;
	logic               accept;
	logic               div_start;
	logic [DEN_W-1:0]   div_num_hi;
	logic [K-1:0]       div_num_lo;
	logic [DEN_W-1:0]   div_den;
	logic               div_done;
	logic [K-1:0]       div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= WINDOW_RESET;
		else if (cfg_we)
			window_q <= cfg_wdata;
	end

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	ccc_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.time_ps    (s_tdata[47:0]),
		.energy_kev (s_tdata[63:48]),
		.cell_id    (s_tdata[73:64]),
		.depth_z    ($signed(s_tdata[89:74])),
		.history_id (s_tdata[121:90]),
		.window_ps  (window_q),
		.req        (req)
	);

	ccc_div #(
		.DEN_W (DEN_W),
		.QUO_W (K)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (div_num_hi),
		.num_lo (div_num_lo),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ccc_seq #(
		.COS_FRAC_BITS (COS_FRAC_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.busy       (busy),
		.div_start  (div_start),
		.div_num_hi (div_num_hi),
		.div_num_lo (div_num_lo),
		.div_den    (div_den),
		.div_done   (div_done),
		.div_quo    (div_quo),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// a closing two-pulse group stalls the input from the next cycle
	a_req_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && accept |=> !s_tready)
		else $error("input not stalled after a cone request");

	// the divider only finishes while a cone is being worked on
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> busy)
		else $error("divider finished while sequencer idle");

	// a new cone only appears after a stalled stretch
	a_cone_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy))
		else $error("cone output without sequencer work");

endmodule
